>>> rtl/gsc_pkg.sv
// Shared types, codes and defaults of the greedy hue seam carver.
// Used by the datapath, controller, top level and checker; no dependencies.
package gsc_pkg;

   // Default sizes
   localparam int MAX_WIDTH_DEF     = 512;
   localparam int MAX_HEIGHT_DEF    = 512;
   localparam int HUE_FRAC_BITS_DEF = 6;

   localparam logic [9:0]  WIDTH_RESET  = 10'd512;
   localparam logic [9:0]  HEIGHT_RESET = 10'd512;
   localparam logic [23:0] COST_MAX     = 24'hFFFFFF;

   // Command codes of a request word
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_CARVE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Status codes of a response word
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ADDR    = 2'd1;
   localparam logic [1:0] STATUS_REFUSED = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [8:0] row;
      logic [8:0] col;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
      logic [8:0]  seam_start;
      logic [23:0] seam_cost;
      logic [9:0]  active_width;
      logic [1:0]  status;
   } rsp_word_type;

   // Datapath operations issued by the controller, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_DECODE,
      OP_LOAD_WR,
      OP_READ_ADDR,
      OP_READ_CAP,
      OP_TOP_RD,
      OP_TOP_CAP,
      OP_MID_RD,
      OP_LEFT_RD,
      OP_RIGHT_RD,
      OP_RIGHT_CAP,
      OP_COMMIT,
      OP_END_WALK,
      OP_SEAM_RD,
      OP_SEAM_CAP,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_CLEAR_WR,
      OP_CARVE_DONE
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_HUE_WAIT,
      ST_LOAD_WR,
      ST_READ_ADDR,
      ST_READ_CAP,
      ST_TOP_RD,
      ST_TOP_CAP,
      ST_MID_RD,
      ST_LEFT_RD,
      ST_RIGHT_RD,
      ST_RIGHT_CAP,
      ST_COMMIT,
      ST_END_WALK,
      ST_SEAM_RD,
      ST_SEAM_CAP,
      ST_SHIFT_CHK,
      ST_SHIFT_WR,
      ST_CARVE_DONE,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type op;
      logic   rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       addr_ok;
      logic       carve_ok;
      logic       hue_busy;
      logic       h_one;
      logic       y_last;
      logic       x_last;
      logic       shift_more;
      logic       rsp_free;
   } stat_type;

endpackage

>>> rtl/gsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gsc_hue_unit.sv
// Fixed-point hue of an RGB pixel, one quotient bit per cycle.
// Depends on nothing but its parameter.
module gsc_hue_unit #(
   parameter int HUE_FRAC_BITS = 6,
   localparam int HUE_FULL = 360 << HUE_FRAC_BITS,
   localparam int HUEW     = $clog2(HUE_FULL)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [7:0]      red,
   input  logic [7:0]      green,
   input  logic [7:0]      blue,
   output logic            busy,
   output logic [HUEW-1:0] hue
);

   localparam int SCALE   = 60 << HUE_FRAC_BITS;
   localparam int NUM_MAX = 2 * (6 * 255 - 1) * SCALE + 255;
   localparam int NW      = $clog2(NUM_MAX + 1);
   localparam int KW      = $clog2(NW + 1);

   logic [7:0]        mx, mn, d;
   logic signed [11:0] rs, gs, bs, ds, n, m;
   logic [10:0]       m_u;
   logic [NW-1:0]     prod, numer, wrapped;
   logic              zero_in;
   logic [9:0]        rem_sh, rem_nx;
   logic              ge;

   logic              busy_ff;
   logic [KW-1:0]     cnt_ff;
   logic [NW-1:0]     n_ff;
   logic [8:0]        rem_ff;
   logic [8:0]        dd_ff;
   logic              zero_ff;

   // Build the rounded numerator 2*m*60*2^F + d; denominator is 2*d
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx)  mx = blue;
      if (green < mn) mn = green;
      if (blue < mn)  mn = blue;
      d  = mx - mn;
      rs = $signed({4'b0, red});
      gs = $signed({4'b0, green});
      bs = $signed({4'b0, blue});
      ds = $signed({4'b0, d});
      if (red == mx) begin
         n = gs - bs;
      end else if (green == mx) begin
         n = (ds <<< 1) + bs - rs;
      end else begin
         n = (ds <<< 2) + rs - gs;
      end
      // fold a negative sector into the top of the circle
      m       = (n < 0) ? n + (ds <<< 2) + (ds <<< 1) : n;
      m_u     = m[10:0];
      prod    = NW'(m_u) * NW'(SCALE);
      numer   = (prod << 1) + NW'(d);
      zero_in = (mx == 8'd0) || (d == 8'd0);
   end

   // One restoring-division step
   always_comb begin
      rem_sh = {rem_ff, n_ff[NW-1]};
      ge     = rem_sh >= {1'b0, dd_ff};
      rem_nx = ge ? rem_sh - {1'b0, dd_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= KW'(NW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - KW'(1);
         if (cnt_ff == KW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= numer;
         rem_ff  <= '0;
         dd_ff   <= {d, 1'b0};
         zero_ff <= zero_in;
      end else if (busy_ff) begin
         n_ff   <= {n_ff[NW-2:0], ge};
         rem_ff <= rem_nx[8:0];
      end
   end

   // Wrap a full circle to zero
   assign wrapped = (n_ff >= NW'(HUE_FULL)) ? n_ff - NW'(HUE_FULL) : n_ff;
   assign hue     = zero_ff ? '0 : HUEW'(wrapped);
   assign busy    = busy_ff;

endmodule

>>> rtl/gsc_datapath.sv
// Datapath of the seam carver: image memory, path memories, walk and shift registers.
// Depends on gsc_pkg, gsc_ram and gsc_hue_unit.
module gsc_datapath #(
   parameter int MAX_WIDTH     = gsc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = gsc_pkg::MAX_HEIGHT_DEF,
   parameter int HUE_FRAC_BITS = gsc_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gsc_pkg::req_word_type req_data,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_data,
   input  gsc_pkg::cmd_type      cmd,
   output gsc_pkg::stat_type     stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output gsc_pkg::rsp_word_type rsp_data
);

   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int RW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW       = $clog2(MAX_HEIGHT + 1);
   localparam int HUE_FULL = 360 << HUE_FRAC_BITS;
   localparam int HUEW     = $clog2(HUE_FULL);
   localparam int PXW      = 24;
   localparam int MW       = PXW + HUEW;
   localparam int AW       = RW + CW;
   localparam int DEPTH    = MAX_HEIGHT << CW;

   function automatic logic [HUEW-1:0] absdiff(input logic [HUEW-1:0] a,
                                                 input logic [HUEW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Control registers
   logic [9:0]    width_ff, height_ff;
   logic [WW-1:0] carved_ff;
   logic [23:0]   best_cost_ff;
   logic          best_sel_ff;
   logic          rsp_valid_ff;

   // Payload registers
   gsc_pkg::req_word_type req_ff;
   gsc_pkg::rsp_word_type rsp_ff;
   logic [1:0]      status_ff;
   logic [PXW-1:0]  pix_res_ff;
   logic [CW-1:0]   start_res_ff;
   logic [23:0]     cost_res_ff;
   logic [CW-1:0]   x_ff, c_ff, nc_ff, best_start_ff;
   logic [RW-1:0]   y_ff;
   logic [HUEW-1:0] cur_ff, nh_ff, best_ff;
   logic [23:0]     cost_ff;

   logic [WW-1:0]   eff_w, aw;
   logic [HW-1:0]   eff_h;
   logic [RW-1:0]   req_r;
   logic [CW-1:0]   req_c, c_m1, c_p1, aw_m1;
   logic            addr_ok, carve_ok, c_left_ok, c_right_ok;
   logic [MW-1:0]   mem_rd, mem_wdata;
   logic [AW-1:0]   mem_raddr, mem_waddr;
   logic            mem_we;
   logic [HUEW-1:0] rd_hue, d_rd, hue_val;
   logic [PXW-1:0]  rd_pix;
   logic [24:0]     cost_sum;
   logic [23:0]     cost_sat;
   logic            path_we, hue_start, hue_busy;
   logic [CW-1:0]   path_wdata, path_rd0, path_rd1, seam_rd;
   logic [1:0]      status_in;

   // Effective sizes and active width
   always_comb begin
      if (width_ff == 10'd0) begin
         eff_w = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (height_ff == 10'd0) begin
         eff_h = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(height_ff);
      end
      aw = (carved_ff < eff_w) ? eff_w - carved_ff : '0;
   end

   assign req_r      = RW'(req_ff.row);
   assign req_c      = CW'(req_ff.col);
   assign addr_ok    = (32'(req_ff.row) < 32'(eff_h)) && (32'(req_ff.col) < 32'(aw));
   assign carve_ok   = aw > WW'(1);
   assign c_m1       = c_ff - CW'(1);
   assign c_p1       = c_ff + CW'(1);
   assign aw_m1      = CW'(aw - WW'(1));
   assign c_left_ok  = c_ff != '0;
   assign c_right_ok = (32'(c_ff) + 1) < 32'(aw);
   assign rd_hue     = mem_rd[MW-1:PXW];
   assign rd_pix     = mem_rd[PXW-1:0];
   assign d_rd       = absdiff(cur_ff, rd_hue);
   assign cost_sum   = {1'b0, cost_ff} + 25'(best_ff);
   assign cost_sat   = cost_sum[24] ? gsc_pkg::COST_MAX : cost_sum[23:0];
   assign seam_rd    = best_sel_ff ? path_rd1 : path_rd0;

   always_comb begin
      if ((req_ff.cmd == gsc_pkg::CMD_LOAD || req_ff.cmd == gsc_pkg::CMD_READ) && !addr_ok) begin
         status_in = gsc_pkg::STATUS_ADDR;
      end else if (req_ff.cmd == gsc_pkg::CMD_CARVE && !carve_ok) begin
         status_in = gsc_pkg::STATUS_REFUSED;
      end else begin
         status_in = gsc_pkg::STATUS_OK;
      end
   end

   // Image memory read and write ports
   always_comb begin
      mem_raddr = {y_ff, c_ff};
      mem_we    = 1'b0;
      mem_waddr = {req_r, req_c};
      mem_wdata = {hue_val, req_ff.red_in, req_ff.green_in, req_ff.blue_in};
      case (cmd.op)
         gsc_pkg::OP_READ_ADDR: mem_raddr = {req_r, req_c};
         gsc_pkg::OP_TOP_RD:    mem_raddr = {RW'(0), x_ff};
         gsc_pkg::OP_LEFT_RD:   mem_raddr = {y_ff, c_m1};
         gsc_pkg::OP_RIGHT_RD:  mem_raddr = {y_ff, c_p1};
         gsc_pkg::OP_SHIFT_RD:  mem_raddr = {y_ff, c_p1};
         gsc_pkg::OP_LOAD_WR:   mem_we    = 1'b1;
         gsc_pkg::OP_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = {y_ff, c_ff};
            mem_wdata = mem_rd;
         end
         gsc_pkg::OP_CLEAR_WR: begin
            mem_we    = 1'b1;
            mem_waddr = {y_ff, aw_m1};
            mem_wdata = '0;
         end
         default: mem_we = 1'b0;
      endcase
   end

   assign path_we    = (cmd.op == gsc_pkg::OP_TOP_CAP) || (cmd.op == gsc_pkg::OP_COMMIT);
   assign path_wdata = (cmd.op == gsc_pkg::OP_TOP_CAP) ? c_ff : nc_ff;
   assign hue_start  = (cmd.op == gsc_pkg::OP_DECODE) && (req_ff.cmd == gsc_pkg::CMD_LOAD);

   gsc_ram #(.WIDTH(MW), .DEPTH(DEPTH), .AW(AW)) u_image (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rd)
   );

   // Candidate path goes to the bank that does not hold the best seam
   gsc_ram #(.WIDTH(CW), .DEPTH(MAX_HEIGHT), .AW(RW)) u_path0 (
      .clock   (clock),
      .wr_en   (path_we && best_sel_ff),
      .wr_addr (y_ff),
      .wr_data (path_wdata),
      .rd_addr (y_ff),
      .rd_data (path_rd0)
   );

   gsc_ram #(.WIDTH(CW), .DEPTH(MAX_HEIGHT), .AW(RW)) u_path1 (
      .clock   (clock),
      .wr_en   (path_we && !best_sel_ff),
      .wr_addr (y_ff),
      .wr_data (path_wdata),
      .rd_addr (y_ff),
      .rd_data (path_rd1)
   );

   gsc_hue_unit #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_hue (
      .clock (clock),
      .reset (reset),
      .start (hue_start),
      .red   (req_ff.red_in),
      .green (req_ff.green_in),
      .blue  (req_ff.blue_in),
      .busy  (hue_busy),
      .hue   (hue_val)
   );

   // Control state: registers, carve count, best seam, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= gsc_pkg::WIDTH_RESET;
         height_ff    <= gsc_pkg::HEIGHT_RESET;
         carved_ff    <= '0;
         best_cost_ff <= gsc_pkg::COST_MAX;
         best_sel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == gsc_pkg::OP_END_WALK && (x_ff == '0 || cost_ff < best_cost_ff)) begin
            best_cost_ff <= cost_ff;
            best_sel_ff  <= !best_sel_ff;
         end
         if (cmd.op == gsc_pkg::OP_CARVE_DONE) begin
            carved_ff <= carved_ff + WW'(1);
         end
         if (csr_write && csr_index == gsc_pkg::CSR_IMAGE_WIDTH) begin
            width_ff  <= csr_data;
            carved_ff <= '0;
         end
         if (csr_write && csr_index == gsc_pkg::CSR_IMAGE_HEIGHT) begin
            height_ff <= csr_data;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk, shift and result registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         gsc_pkg::OP_ACCEPT: begin
            req_ff       <= req_data;
            pix_res_ff   <= '0;
            start_res_ff <= '0;
            cost_res_ff  <= '0;
         end
         gsc_pkg::OP_DECODE: begin
            status_ff <= status_in;
            x_ff      <= '0;
            y_ff      <= '0;
         end
         gsc_pkg::OP_READ_CAP: pix_res_ff <= rd_pix;
         gsc_pkg::OP_TOP_RD:   c_ff <= x_ff;
         gsc_pkg::OP_TOP_CAP: begin
            cur_ff  <= rd_hue;
            cost_ff <= 24'(rd_hue);
            y_ff    <= RW'(1);
         end
         gsc_pkg::OP_LEFT_RD: begin
            best_ff <= d_rd;
            nc_ff   <= c_ff;
            nh_ff   <= rd_hue;
         end
         gsc_pkg::OP_RIGHT_RD: begin
            if (c_left_ok && d_rd < best_ff) begin
               best_ff <= d_rd;
               nc_ff   <= c_m1;
               nh_ff   <= rd_hue;
            end
         end
         gsc_pkg::OP_RIGHT_CAP: begin
            if (c_right_ok && d_rd < best_ff) begin
               best_ff <= d_rd;
               nc_ff   <= c_p1;
               nh_ff   <= rd_hue;
            end
         end
         gsc_pkg::OP_COMMIT: begin
            cost_ff <= cost_sat;
            c_ff    <= nc_ff;
            cur_ff  <= nh_ff;
            y_ff    <= y_ff + RW'(1);
         end
         gsc_pkg::OP_END_WALK: begin
            if (x_ff == '0 || cost_ff < best_cost_ff) begin
               best_start_ff <= x_ff;
            end
            x_ff <= x_ff + CW'(1);
            y_ff <= '0;
         end
         gsc_pkg::OP_SEAM_CAP:   c_ff <= seam_rd;
         gsc_pkg::OP_SHIFT_WR:   c_ff <= c_p1;
         gsc_pkg::OP_CLEAR_WR:   y_ff <= y_ff + RW'(1);
         gsc_pkg::OP_CARVE_DONE: begin
            start_res_ff <= best_start_ff;
            cost_res_ff  <= best_cost_ff;
         end
         default: ;
      endcase
      if (cmd.rsp_load) begin
         rsp_ff.red_out      <= pix_res_ff[23:16];
         rsp_ff.green_out    <= pix_res_ff[15:8];
         rsp_ff.blue_out     <= pix_res_ff[7:0];
         rsp_ff.seam_start   <= 9'(start_res_ff);
         rsp_ff.seam_cost    <= cost_res_ff;
         rsp_ff.active_width <= 10'(aw);
         rsp_ff.status       <= status_ff;
      end
   end

   assign stat.cmd        = req_ff.cmd;
   assign stat.addr_ok    = addr_ok;
   assign stat.carve_ok   = carve_ok;
   assign stat.hue_busy   = hue_busy;
   assign stat.h_one      = eff_h == HW'(1);
   assign stat.y_last     = (32'(y_ff) + 1) == 32'(eff_h);
   assign stat.x_last     = (32'(x_ff) + 1) == 32'(aw);
   assign stat.shift_more = c_right_ok;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/gsc_ctrl.sv
// Controller of the seam carver: sequences load, read and carve over the datapath.
// Depends on gsc_pkg.
module gsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gsc_pkg::stat_type stat,
   output gsc_pkg::cmd_type  cmd
);

   gsc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath operation
   always_comb begin
      state_in     = state_ff;
      cmd.op       = gsc_pkg::OP_NONE;
      cmd.rsp_load = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         gsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = gsc_pkg::OP_ACCEPT;
               state_in = gsc_pkg::ST_DECODE;
            end
         end
         gsc_pkg::ST_DECODE: begin
            cmd.op = gsc_pkg::OP_DECODE;
            case (stat.cmd)
               gsc_pkg::CMD_LOAD:
                  state_in = stat.addr_ok ? gsc_pkg::ST_HUE_WAIT : gsc_pkg::ST_RESP;
               gsc_pkg::CMD_READ:
                  state_in = stat.addr_ok ? gsc_pkg::ST_READ_ADDR : gsc_pkg::ST_RESP;
               gsc_pkg::CMD_CARVE:
                  state_in = stat.carve_ok ? gsc_pkg::ST_TOP_RD : gsc_pkg::ST_RESP;
               default: state_in = gsc_pkg::ST_RESP;
            endcase
         end
         gsc_pkg::ST_HUE_WAIT: begin
            if (!stat.hue_busy) begin
               state_in = gsc_pkg::ST_LOAD_WR;
            end
         end
         gsc_pkg::ST_LOAD_WR: begin
            cmd.op   = gsc_pkg::OP_LOAD_WR;
            state_in = gsc_pkg::ST_RESP;
         end
         gsc_pkg::ST_READ_ADDR: begin
            cmd.op   = gsc_pkg::OP_READ_ADDR;
            state_in = gsc_pkg::ST_READ_CAP;
         end
         gsc_pkg::ST_READ_CAP: begin
            cmd.op   = gsc_pkg::OP_READ_CAP;
            state_in = gsc_pkg::ST_RESP;
         end
         // Walk one start column down the image
         gsc_pkg::ST_TOP_RD: begin
            cmd.op   = gsc_pkg::OP_TOP_RD;
            state_in = gsc_pkg::ST_TOP_CAP;
         end
         gsc_pkg::ST_TOP_CAP: begin
            cmd.op   = gsc_pkg::OP_TOP_CAP;
            state_in = stat.h_one ? gsc_pkg::ST_END_WALK : gsc_pkg::ST_MID_RD;
         end
         gsc_pkg::ST_MID_RD: begin
            cmd.op   = gsc_pkg::OP_MID_RD;
            state_in = gsc_pkg::ST_LEFT_RD;
         end
         gsc_pkg::ST_LEFT_RD: begin
            cmd.op   = gsc_pkg::OP_LEFT_RD;
            state_in = gsc_pkg::ST_RIGHT_RD;
         end
         gsc_pkg::ST_RIGHT_RD: begin
            cmd.op   = gsc_pkg::OP_RIGHT_RD;
            state_in = gsc_pkg::ST_RIGHT_CAP;
         end
         gsc_pkg::ST_RIGHT_CAP: begin
            cmd.op   = gsc_pkg::OP_RIGHT_CAP;
            state_in = gsc_pkg::ST_COMMIT;
         end
         gsc_pkg::ST_COMMIT: begin
            cmd.op   = gsc_pkg::OP_COMMIT;
            state_in = stat.y_last ? gsc_pkg::ST_END_WALK : gsc_pkg::ST_MID_RD;
         end
         gsc_pkg::ST_END_WALK: begin
            cmd.op   = gsc_pkg::OP_END_WALK;
            state_in = stat.x_last ? gsc_pkg::ST_SEAM_RD : gsc_pkg::ST_TOP_RD;
         end
         // Shift each row left over the seam
         gsc_pkg::ST_SEAM_RD: begin
            cmd.op   = gsc_pkg::OP_SEAM_RD;
            state_in = gsc_pkg::ST_SEAM_CAP;
         end
         gsc_pkg::ST_SEAM_CAP: begin
            cmd.op   = gsc_pkg::OP_SEAM_CAP;
            state_in = gsc_pkg::ST_SHIFT_CHK;
         end
         gsc_pkg::ST_SHIFT_CHK: begin
            if (stat.shift_more) begin
               cmd.op   = gsc_pkg::OP_SHIFT_RD;
               state_in = gsc_pkg::ST_SHIFT_WR;
            end else begin
               cmd.op   = gsc_pkg::OP_CLEAR_WR;
               state_in = stat.y_last ? gsc_pkg::ST_CARVE_DONE : gsc_pkg::ST_SEAM_RD;
            end
         end
         gsc_pkg::ST_SHIFT_WR: begin
            cmd.op   = gsc_pkg::OP_SHIFT_WR;
            state_in = gsc_pkg::ST_SHIFT_CHK;
         end
         gsc_pkg::ST_CARVE_DONE: begin
            cmd.op   = gsc_pkg::OP_CARVE_DONE;
            state_in = gsc_pkg::ST_RESP;
         end
         // Hold until the output register is free
         gsc_pkg::ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = gsc_pkg::ST_IDLE;
            end
         end
         default: state_in = gsc_pkg::ST_IDLE;
      endcase
   end

endmodule

>>> rtl/greedy_seam_carver_top.sv
// Greedy hue seam carver. A load waits for the hue divider (one hue bit a cycle) before its
// write; a carve walks every start column down the image, then shifts each row over the seam.
// One word is worked at a time; the single image-memory port sets the carve time.
// A finished word waits in the output register while the next word is accepted.
// Synchronous reset clears control state, sets both size registers to 512 and the
// carve count to zero; image and path memories are not cleared.
module greedy_seam_carver_top #(
   parameter int MAX_WIDTH     = gsc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = gsc_pkg::MAX_HEIGHT_DEF,
   parameter int HUE_FRAC_BITS = gsc_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gsc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gsc_pkg::rsp_word_type rsp_data,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_data
);

   gsc_pkg::cmd_type  cmd;
   gsc_pkg::stat_type stat;

   gsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gsc_datapath #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/gsc_checker.sv
// Port-level checks of the seam carver, bound to the top level.
// Depends on gsc_pkg and greedy_seam_carver_top.
module gsc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input gsc_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input gsc_pkg::rsp_word_type rsp_data,
   input logic                  csr_write,
   input logic [1:0]            csr_index,
   input logic [9:0]            csr_data
);

   // Hold a stalled response word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // Drop ready after a request word is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous word still in work");

   // Clear a failed word's payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != gsc_pkg::STATUS_OK |->
         rsp_data.seam_cost == 24'd0 && rsp_data.red_out == 8'd0 &&
         rsp_data.green_out == 8'd0 && rsp_data.blue_out == 8'd0)
      else $error("failed word carries data");

   // Never report an unused status code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("unused status code");

   // Come out of reset with no response pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind greedy_seam_carver_top gsc_checker u_gsc_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the greedy hue seam carver: loads, reads, carves and size changes.
// Depends on gsc_pkg and greedy_seam_carver_top; predicts every response word on its own.
module tb_top;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ROW_PITCH = 512;
   localparam int HUE_WRAP = 360 * 64;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   // Scoreboard: image mirror, carve predictor and queue of pending responses
   class carve_scoreboard;
      bit [23:0] pixel_mem [ROW_PITCH*ROW_PITCH];
      bit [14:0] hue_mem [ROW_PITCH*ROW_PITCH];
      int width_reg = 512;
      int height_reg = 512;
      int carved = 0;
      int errors = 0;
      int words_in = 0;
      int words_out = 0;
      int carves_done = 0;
      gsc_pkg::rsp_word_type pending_rsp [$];

      function int cols_full();
         if (width_reg < 1) return 1;
         if (width_reg > 512) return 512;
         return width_reg;
      endfunction

      function int rows();
         if (height_reg < 1) return 1;
         if (height_reg > 512) return 512;
         return height_reg;
      endfunction

      function int active_cols();
         return (carved < cols_full()) ? cols_full() - carved : 0;
      endfunction

      function void write_size(logic [1:0] idx, logic [9:0] val);
         if (idx == gsc_pkg::CSR_IMAGE_WIDTH) begin
            width_reg = val;
            carved = 0;
         end else if (idx == gsc_pkg::CSR_IMAGE_HEIGHT) begin
            height_reg = val;
         end
      endfunction

      // hue in 1/64 degree, rounded half up, wrapped at a full turn
      function bit [14:0] hue_fixed(int r, int g, int b);
         int mx, mn, d, n;
         longint num, h;
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d = mx - mn;
         if (mx == 0 || d == 0) return '0;
         if (r == mx) n = g - b;
         else if (g == mx) n = 2 * d + (b - r);
         else n = 4 * d + (r - g);
         num = longint'(n) * 60 * 64;
         if (num < 0) num += longint'(HUE_WRAP) * d;
         h = (2 * num + d) / (2 * d);
         if (h >= HUE_WRAP) h -= HUE_WRAP;
         return h[14:0];
      endfunction

      function int hue_gap(int a, int b);
         return (a > b) ? a - b : b - a;
      endfunction

      // try every start column, keep the cheapest greedy path, then close the gap
      function void carve_seam(output int start, output int cost);
         int aw, h, x, y, c, nc, cur, nh, step, sum, best, side;
         int path [512];
         int seam [512];
         aw = active_cols();
         h = rows();
         best = gsc_pkg::COST_MAX;
         for (x = 0; x < aw; x++) begin
            c = x;
            cur = hue_mem[c];
            sum = cur;
            path[0] = c;
            for (y = 1; y < h; y++) begin
               nc = c;
               nh = hue_mem[y*ROW_PITCH + c];
               step = hue_gap(cur, nh);
               if (c > 0) begin
                  side = hue_mem[y*ROW_PITCH + c - 1];
                  if (hue_gap(cur, side) < step) begin
                     step = hue_gap(cur, side); nc = c - 1; nh = side;
                  end
               end
               if (c + 1 < aw) begin
                  side = hue_mem[y*ROW_PITCH + c + 1];
                  if (hue_gap(cur, side) < step) begin
                     step = hue_gap(cur, side); nc = c + 1; nh = side;
                  end
               end
               sum += step;
               if (sum > gsc_pkg::COST_MAX) sum = gsc_pkg::COST_MAX;
               c = nc;
               cur = nh;
               path[y] = c;
            end
            if (x == 0 || sum < best) begin
               best = sum;
               for (y = 0; y < h; y++) seam[y] = path[y];
            end
         end
         for (y = 0; y < h; y++) begin
            for (c = seam[y]; c + 1 < aw; c++) begin
               pixel_mem[y*ROW_PITCH + c] = pixel_mem[y*ROW_PITCH + c + 1];
               hue_mem[y*ROW_PITCH + c] = hue_mem[y*ROW_PITCH + c + 1];
            end
            pixel_mem[y*ROW_PITCH + aw - 1] = '0;
            hue_mem[y*ROW_PITCH + aw - 1] = '0;
         end
         start = seam[0];
         cost = best;
         carved++;
         carves_done++;
      endfunction

      // note an accepted request word and queue its response
      function void note_request(gsc_pkg::req_word_type w);
         gsc_pkg::rsp_word_type e;
         int addr, start, cost;
         e = '0;
         words_in++;
         addr = w.row * ROW_PITCH + w.col;
         if (w.cmd == gsc_pkg::CMD_LOAD || w.cmd == gsc_pkg::CMD_READ) begin
            if (w.row >= rows() || w.col >= active_cols()) begin
               e.status = gsc_pkg::STATUS_ADDR;
            end else if (w.cmd == gsc_pkg::CMD_LOAD) begin
               pixel_mem[addr] = {w.red_in, w.green_in, w.blue_in};
               hue_mem[addr] = hue_fixed(w.red_in, w.green_in, w.blue_in);
            end else begin
               {e.red_out, e.green_out, e.blue_out} = pixel_mem[addr];
            end
         end else if (w.cmd == gsc_pkg::CMD_CARVE) begin
            if (active_cols() <= 1) begin
               e.status = gsc_pkg::STATUS_REFUSED;
            end else begin
               carve_seam(start, cost);
               e.seam_start = 9'(start);
               e.seam_cost = 24'(cost);
            end
         end
         e.active_width = 10'(active_cols());
         pending_rsp.push_back(e);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_response(gsc_pkg::rsp_word_type g);
         gsc_pkg::rsp_word_type e;
         words_out++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response word", g.status, -1);
            return;
         end
         e = pending_rsp.pop_front();
         if (g.red_out !== e.red_out) report_mismatch("red_out", g.red_out, e.red_out);
         if (g.green_out !== e.green_out)
            report_mismatch("green_out", g.green_out, e.green_out);
         if (g.blue_out !== e.blue_out) report_mismatch("blue_out", g.blue_out, e.blue_out);
         if (g.seam_start !== e.seam_start)
            report_mismatch("seam_start", g.seam_start, e.seam_start);
         if (g.seam_cost !== e.seam_cost)
            report_mismatch("seam_cost", g.seam_cost, e.seam_cost);
         if (g.active_width !== e.active_width)
            report_mismatch("active_width", g.active_width, e.active_width);
         if (g.status !== e.status) report_mismatch("status", g.status, e.status);
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   gsc_pkg::req_word_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   gsc_pkg::rsp_word_type rsp_data;
   logic csr_write;
   logic [1:0] csr_index;
   logic [9:0] csr_data;

   carve_scoreboard sb;
   int burst_left = 0;
   int gap_max = 4;
   int stall_pct = 30;
   bit hold_req = 0;
   int idle_cycles = 0;

   greedy_seam_carver_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check every accepted response word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 0;
         end else if (stall_pct == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
         end
      end
   end

   function automatic gsc_pkg::req_word_type make_word(logic [1:0] cmd, int row, int col,
                                                       logic [23:0] rgb);
      gsc_pkg::req_word_type w;
      w.cmd = cmd;
      w.row = 9'(row);
      w.col = 9'(col);
      {w.red_in, w.green_in, w.blue_in} = rgb;
      return w;
   endfunction

   // half the colors come from a small set so hue ties are common
   function automatic logic [23:0] pick_color();
      logic [23:0] shades [6] = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080,
                                  24'hFF00C0, 24'h10F020};
      if ($urandom_range(1, 0)) return shades[$urandom_range(5, 0)];
      return 24'($urandom());
   endfunction

   // offer one word, hold it until taken, then maybe pause
   task send_word(gsc_pkg::req_word_type w);
      int gap;
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(8, 1);
         gap = $urandom_range(gap_max, 0);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // drop valid and wait until every response is back and the block is idle
   task drain();
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task write_sizes(logic [9:0] w, logic [9:0] h);
      drain();
      csr_write <= 1'b1;
      csr_index <= gsc_pkg::CSR_IMAGE_WIDTH;
      csr_data <= w;
      @(posedge clock);
      sb.write_size(gsc_pkg::CSR_IMAGE_WIDTH, w);
      csr_index <= gsc_pkg::CSR_IMAGE_HEIGHT;
      csr_data <= h;
      @(posedge clock);
      sb.write_size(gsc_pkg::CSR_IMAGE_HEIGHT, h);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task load_all();
      int r, c;
      for (r = 0; r < sb.rows(); r++)
         for (c = 0; c < sb.active_cols(); c++)
            send_word(make_word(gsc_pkg::CMD_LOAD, r, c, pick_color()));
   endtask

   // one random word: mostly in-range reads, loads and carves
   task send_random();
      int sel, aw, h, r, c;
      logic [1:0] cmd;
      sel = $urandom_range(99, 0);
      aw = sb.active_cols();
      h = sb.rows();
      r = $urandom_range(h - 1, 0);
      c = (aw > 0) ? $urandom_range(aw - 1, 0) : 0;
      if (sel < 40) begin
         send_word(make_word(gsc_pkg::CMD_READ, r, c, 24'($urandom())));
      end else if (sel < 55) begin
         send_word(make_word(gsc_pkg::CMD_LOAD, r, c, pick_color()));
      end else if (sel < 65) begin
         cmd = $urandom_range(1, 0) ? gsc_pkg::CMD_LOAD : gsc_pkg::CMD_READ;
         if ($urandom_range(1, 0)) r = $urandom_range(511, h);
         else c = $urandom_range(511, aw);
         send_word(make_word(cmd, r, c, 24'($urandom())));
      end else if (sel < 90) begin
         send_word(make_word(gsc_pkg::CMD_CARVE, $urandom(), $urandom(), 24'($urandom())));
      end else begin
         send_word(make_word(CMD_UNUSED, $urandom(), $urandom(), 24'($urandom())));
      end
   endtask

   initial begin
      int k, phase, random_items;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = gsc_pkg::CSR_IMAGE_WIDTH;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner addresses at the reset size
      send_word(make_word(gsc_pkg::CMD_LOAD, 511, 511, 24'hFFFFFF));
      send_word(make_word(gsc_pkg::CMD_LOAD, 0, 0, 24'h000000));
      send_word(make_word(gsc_pkg::CMD_READ, 511, 511, 24'h000000));
      send_word(make_word(gsc_pkg::CMD_READ, 0, 0, 24'hFFFFFF));
      send_word(make_word(CMD_UNUSED, 511, 511, 24'hFFFFFF));

      // 3x2 image covering each hue branch, then carve down to one column
      write_sizes(10'd3, 10'd2);
      send_word(make_word(gsc_pkg::CMD_LOAD, 0, 0, 24'hFF0000));
      send_word(make_word(gsc_pkg::CMD_LOAD, 0, 1, 24'h00FF00));
      send_word(make_word(gsc_pkg::CMD_LOAD, 0, 2, 24'h0000FF));
      send_word(make_word(gsc_pkg::CMD_LOAD, 1, 0, 24'h808080));
      send_word(make_word(gsc_pkg::CMD_LOAD, 1, 1, 24'h000000));
      send_word(make_word(gsc_pkg::CMD_LOAD, 1, 2, 24'hFF00C0));
      send_word(make_word(gsc_pkg::CMD_CARVE, 0, 0, 24'h0));
      send_word(make_word(gsc_pkg::CMD_READ, 1, 0, 24'h0));
      send_word(make_word(gsc_pkg::CMD_READ, 0, 2, 24'h0));
      send_word(make_word(gsc_pkg::CMD_LOAD, 2, 0, 24'h123456));
      send_word(make_word(gsc_pkg::CMD_CARVE, 0, 0, 24'h0));
      send_word(make_word(gsc_pkg::CMD_CARVE, 0, 0, 24'h0));

      // sizes below the floor saturate to one pixel
      write_sizes(10'd0, 10'd0);
      send_word(make_word(gsc_pkg::CMD_LOAD, 0, 0, 24'h0C8040));
      send_word(make_word(gsc_pkg::CMD_CARVE, 0, 0, 24'h0));
      send_word(make_word(gsc_pkg::CMD_READ, 0, 0, 24'h0));
      write_sizes(10'd1, 10'd1);
      send_word(make_word(gsc_pkg::CMD_READ, 0, 0, 24'h0));

      // sizes above the ceiling saturate to the maximum
      write_sizes(10'h3FF, 10'h3FF);
      send_word(make_word(gsc_pkg::CMD_LOAD, 511, 511, 24'hA5F00F));
      send_word(make_word(gsc_pkg::CMD_READ, 511, 511, 24'h0));
      write_sizes(10'd512, 10'd512);
      send_word(make_word(gsc_pkg::CMD_READ, 511, 511, 24'h0));

      // random phases: new size, full load, then a random mix
      random_items = sb.words_in;
      phase = 0;
      while (sb.words_in - random_items < 70) begin
         gap_max = (phase % 3 == 0) ? 0 : $urandom_range(6, 1);
         stall_pct = (phase % 3 == 1) ? 0 : $urandom_range(70, 10);
         write_sizes(10'($urandom_range(10, 2)), 10'($urandom_range(6, 1)));
         if (phase == 1) begin
            gap_max = 0;
            hold_req = 1;
         end
         load_all();
         for (k = 0; k < $urandom_range(18, 10); k++) send_random();
         phase++;
      end

      drain();
      $display("covered %0d request words in %0d phases, %0d seams carved",
               sb.words_in, phase, sb.carves_done);
      $display("checked %0d response words, %0d mismatches", sb.words_out, sb.errors);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
